// ===== hw/rtl/bhpq_pkg.sv =====
// Shared types and constants of the binary heap priority queue.
`default_nettype none

package bhpq_pkg;

    localparam int CAPACITY_DEF  = 256;
    localparam int KEY_WIDTH_DEF = 32;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

    // where a level cell takes its write data from
    typedef enum logic [1:0] {
        WR_EXT        = 2'd0,
        WR_PARENT     = 2'd1,
        WR_CHILD_EVEN = 2'd2,
        WR_CHILD_ODD  = 2'd3
    } t_wr_src;

endpackage

`default_nettype wire

// ===== hw/rtl/bhpq_level.sv =====
// Heap level: even/odd entry banks with registered read, or root register; neighbor writes.
`default_nettype none

module bhpq_level
    import bhpq_pkg::*;
#(
    parameter int LEVEL     = 0,
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int OFS_W     = 2
) (
    input  wire logic                 i_clk,
    input  wire logic [OFS_W-1:0]     i_rd_ofs,
    input  wire logic                 i_wr_en,
    input  wire logic [OFS_W-1:0]     i_wr_ofs,
    input  wire t_wr_src              i_wr_src,
    input  wire logic [KEY_WIDTH-1:0] i_wr_key,
    input  wire logic [KEY_WIDTH-1:0] i_par_key,
    input  wire logic [KEY_WIDTH-1:0] i_chl_even,
    input  wire logic [KEY_WIDTH-1:0] i_chl_odd,
    output logic      [KEY_WIDTH-1:0] o_rd_even,
    output logic      [KEY_WIDTH-1:0] o_rd_odd,
    output logic      [KEY_WIDTH-1:0] o_rd_key
);

    localparam int FULL_ENT = 1 << LEVEL;
    localparam int LEFT_ENT = CAPACITY - FULL_ENT + 1;
    localparam int ENT      = (FULL_ENT < LEFT_ENT) ? FULL_ENT : LEFT_ENT;
    localparam int BDEPTH   = (ENT + 1) / 2;
    localparam int AW       = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

    logic [KEY_WIDTH-1:0] w_wr_data;

    always_comb begin
        unique case (i_wr_src)
            WR_EXT:        w_wr_data = i_wr_key;
            WR_PARENT:     w_wr_data = i_par_key;
            WR_CHILD_EVEN: w_wr_data = i_chl_even;
            WR_CHILD_ODD:  w_wr_data = i_chl_odd;
            default:       w_wr_data = i_wr_key;
        endcase
    end

    if (LEVEL == 0) begin : g_root
        logic [KEY_WIDTH-1:0] r_root;

        always_ff @(posedge i_clk) begin
            if (i_wr_en) begin
                r_root <= w_wr_data;
            end
        end

        assign o_rd_even = r_root;
        assign o_rd_odd  = r_root;
        assign o_rd_key  = r_root;
    end else begin : g_bank
        logic [KEY_WIDTH-1:0] r_even [BDEPTH];
        logic [KEY_WIDTH-1:0] r_odd  [BDEPTH];
        logic [KEY_WIDTH-1:0] r_rd_even;
        logic [KEY_WIDTH-1:0] r_rd_odd;
        logic                 r_rd_sel;
        logic [AW-1:0]        w_wr_addr;
        logic [AW-1:0]        w_rd_addr;

        assign w_wr_addr = i_wr_ofs[AW:1];
        assign w_rd_addr = i_rd_ofs[AW:1];

        always_ff @(posedge i_clk) begin
            if (i_wr_en) begin
                if (i_wr_ofs[0]) begin
                    r_odd[w_wr_addr] <= w_wr_data;
                end else begin
                    r_even[w_wr_addr] <= w_wr_data;
                end
            end
            r_rd_even <= r_even[w_rd_addr];
            r_rd_odd  <= r_odd[w_rd_addr];
            r_rd_sel  <= i_rd_ofs[0];
        end

        assign o_rd_even = r_rd_even;
        assign o_rd_odd  = r_rd_odd;
        assign o_rd_key  = r_rd_sel ? r_rd_odd : r_rd_even;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/binary_heap_priority_queue.sv =====
// Top level of the binary heap priority queue: level cells and the sift sequencer.
//
//  channel   | direction | handshake        | payload
//  ----------+-----------+------------------+--------------------------------------------
//  command   | in        | start, busy      | i_action, i_key
//  result    | out       | o_done (strobe)  | o_status, o_popped_key, o_top_key,
//            |           |                  | o_top_valid, o_count
//  config    | in        | i_cfg_we         | i_cfg_wdata (order mode)
//
// A push reads all ancestors on the leaf path together, one level per cell, in S_PUSH_RD,
// and in S_PUSH_WR shifts down by one level each of them that the new key beats.
// A pop fetches the last entry in S_POP_RDL and S_POP_LAST, then sifts it down; each
// level takes a registered bank read of the child pair in S_POP_RD and a compare and
// write in S_POP_CMP.
// Pop on empty, pop of the only key and push when full answer straight from S_IDLE.
// Reset is synchronous and clears count and order; entry banks are not cleared.
// Each result beat is shown for exactly one cycle; the receiver cannot stall.
`default_nettype none

module binary_heap_priority_queue
    import bhpq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_wdata,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_action,
    input  wire logic [KEY_WIDTH-1:0]                i_key,
    output logic                                     o_done,
    output logic [1:0]                               o_status,
    output logic [KEY_WIDTH-1:0]                     o_popped_key,
    output logic [KEY_WIDTH-1:0]                     o_top_key,
    output logic                                     o_top_valid,
    output logic [$clog2(CAPACITY+1)-1:0]            o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NLEV  = CNT_W;
    localparam int OFS_W = (NLEV - 1 > 2) ? NLEV - 1 : 2;
    localparam int LW    = $clog2(NLEV);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_WR,
        S_POP_RDL,
        S_POP_LAST,
        S_POP_RD,
        S_POP_CMP
    } t_state;

    function automatic logic f_beats(input logic ord, input logic [KEY_WIDTH-1:0] a,
                                     input logic [KEY_WIDTH-1:0] b);
        return ord ? (a < b) : (a > b);
    endfunction

    // level of a heap position given index + 1
    function automatic logic [LW-1:0] f_lev(input logic [CNT_W-1:0] v);
        logic [LW-1:0] lev;
        lev = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (v[i]) begin
                lev = LW'(i);
            end
        end
        return lev;
    endfunction

    // offset inside its level given index + 1
    function automatic logic [OFS_W-1:0] f_ofs(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] rest;
        rest = v;
        for (int i = 0; i < CNT_W; i++) begin
            if (v[i]) begin
                rest = v & ~(CNT_W'(1) << i);
            end
        end
        return OFS_W'(rest);
    endfunction

    t_state               r_state;
    logic                 r_order;
    logic [CNT_W-1:0]     r_cnt;
    logic [KEY_WIDTH-1:0] r_top;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] r_popped;
    logic [LW-1:0]        r_lev;
    logic [OFS_W-1:0]     r_ofs;
    logic [LW-1:0]        r_pos_lev;
    logic [OFS_W-1:0]     r_pos_ofs;
    logic [CNT_W-1:0]     r_idx;

    logic                 r_done;
    t_status              r_status;
    logic [KEY_WIDTH-1:0] r_out_popped;
    logic [KEY_WIDTH-1:0] r_out_top;
    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_out_count;

    logic [KEY_WIDTH-1:0] w_rd_even [NLEV];
    logic [KEY_WIDTH-1:0] w_rd_odd  [NLEV];
    logic [KEY_WIDTH-1:0] w_rd_key  [NLEV];
    logic [OFS_W-1:0]     w_rd_ofs  [NLEV];
    logic [OFS_W-1:0]     w_path_ofs[NLEV];
    logic                 w_wr_en   [NLEV];
    logic [OFS_W-1:0]     w_wr_ofs  [NLEV];
    t_wr_src              w_wr_src  [NLEV];

    logic [NLEV-1:0]      w_beat;
    logic [NLEV-1:0]      w_beat_par;
    logic [NLEV-1:0]      w_shift;
    logic [NLEV-1:0]      w_land;

    logic                 w_accept;
    logic [KEY_WIDTH-1:0] w_last_key;
    logic [KEY_WIDTH-1:0] w_chl_even;
    logic [KEY_WIDTH-1:0] w_chl_odd;
    logic [CNT_W:0]       w_left;
    logic [CNT_W:0]       w_right;
    logic                 w_has_left;
    logic                 w_has_right;
    logic                 w_pick_r;
    logic [KEY_WIDTH-1:0] w_pick;
    logic                 w_sink;

    assign w_accept = start && !busy;

    // ---------------------------------------------------------------- level cells
    for (genvar l = 0; l < NLEV; l++) begin : g_lvl
        logic [KEY_WIDTH-1:0] w_par;
        logic [KEY_WIDTH-1:0] w_ce;
        logic [KEY_WIDTH-1:0] w_co;

        if (l == 0) begin : g_top
            assign w_par = '0;
        end else begin : g_mid
            assign w_par = w_rd_key[l-1];
        end

        if (l == NLEV - 1) begin : g_leaf
            assign w_ce = '0;
            assign w_co = '0;
        end else begin : g_inner
            assign w_ce = w_rd_even[l+1];
            assign w_co = w_rd_odd[l+1];
        end

        bhpq_level #(
            .LEVEL     (l),
            .CAPACITY  (CAPACITY),
            .KEY_WIDTH (KEY_WIDTH),
            .OFS_W     (OFS_W)
        ) u_level (
            .i_clk      (i_clk),
            .i_rd_ofs   (w_rd_ofs[l]),
            .i_wr_en    (w_wr_en[l]),
            .i_wr_ofs   (w_wr_ofs[l]),
            .i_wr_src   (w_wr_src[l]),
            .i_wr_key   (r_key),
            .i_par_key  (w_par),
            .i_chl_even (w_ce),
            .i_chl_odd  (w_co),
            .o_rd_even  (w_rd_even[l]),
            .o_rd_odd   (w_rd_odd[l]),
            .o_rd_key   (w_rd_key[l])
        );
    end

    // ---------------------------------------------------------------- push path
    always_comb begin
        logic acc;
        acc = 1'b1;
        for (int l = 0; l < NLEV; l++) begin
            w_beat[l] = (LW'(l) < r_lev) && f_beats(r_order, r_key, w_rd_key[l]);
        end
        w_beat_par = {w_beat[NLEV-2:0], 1'b0};
        // walk up from the leaf: shift down each ancestor the key beats, land below the first it does not
        for (int l = NLEV - 1; l >= 0; l--) begin
            w_shift[l] = 1'b0;
            w_land[l]  = 1'b0;
            if (LW'(l) <= r_lev) begin
                w_shift[l] = w_beat_par[l] && acc;
                w_land[l]  = !w_shift[l] && acc;
                acc        = w_shift[l];
            end
        end
    end

    // ---------------------------------------------------------------- pop path
    always_comb begin
        w_last_key = '0;
        w_chl_even = '0;
        w_chl_odd  = '0;
        for (int l = 0; l < NLEV; l++) begin
            if (LW'(l) == r_lev) begin
                w_last_key = w_rd_key[l];
            end
            if (LW'(l) == r_pos_lev + LW'(1)) begin
                w_chl_even = w_rd_even[l];
                w_chl_odd  = w_rd_odd[l];
            end
        end
        w_left      = {r_idx, 1'b1};
        w_right     = w_left + (CNT_W+1)'(1);
        w_has_left  = w_left < {1'b0, r_cnt};
        w_has_right = w_right < {1'b0, r_cnt};
        // on a tie the right child is taken
        w_pick_r    = w_has_right && !f_beats(r_order, w_chl_even, w_chl_odd);
        w_pick      = w_pick_r ? w_chl_odd : w_chl_even;
        w_sink      = w_has_left && f_beats(r_order, w_pick, r_key);
    end

    // ---------------------------------------------------------------- cell controls
    always_comb begin
        for (int l = 0; l < NLEV; l++) begin
            w_path_ofs[l] = r_ofs >> (r_lev - LW'(l));
            w_rd_ofs[l]   = (r_state == S_POP_RD) ? (r_pos_ofs << 1) : w_path_ofs[l];
            if (r_state == S_POP_CMP) begin
                w_wr_en[l]  = (LW'(l) == r_pos_lev);
                w_wr_ofs[l] = r_pos_ofs;
                if (w_sink) begin
                    w_wr_src[l] = w_pick_r ? WR_CHILD_ODD : WR_CHILD_EVEN;
                end else begin
                    w_wr_src[l] = WR_EXT;
                end
            end else begin
                w_wr_en[l]  = (r_state == S_PUSH_WR) && (w_shift[l] || w_land[l]);
                w_wr_ofs[l] = w_path_ofs[l];
                w_wr_src[l] = w_shift[l] ? WR_PARENT : WR_EXT;
            end
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_order <= 1'b0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_key <= i_key;
                        if (i_action == ACT_PUSH) begin
                            if (r_cnt == CNT_W'(CAPACITY)) begin
                                r_done       <= 1'b1;
                                r_status     <= ST_PUSH_FULL;
                                r_out_popped <= '0;
                                r_out_top    <= r_top;
                                r_out_valid  <= 1'b1;
                                r_out_count  <= r_cnt;
                            end else begin
                                r_lev   <= f_lev(r_cnt + CNT_W'(1));
                                r_ofs   <= f_ofs(r_cnt + CNT_W'(1));
                                r_state <= S_PUSH_RD;
                            end
                        end else begin
                            if (r_cnt == '0) begin
                                r_done       <= 1'b1;
                                r_status     <= ST_POP_EMPTY;
                                r_out_popped <= '0;
                                r_out_top    <= '0;
                                r_out_valid  <= 1'b0;
                                r_out_count  <= r_cnt;
                            end else if (r_cnt == CNT_W'(1)) begin
                                r_cnt        <= '0;
                                r_done       <= 1'b1;
                                r_status     <= ST_DONE;
                                r_out_popped <= r_top;
                                r_out_top    <= '0;
                                r_out_valid  <= 1'b0;
                                r_out_count  <= '0;
                            end else begin
                                // last entry sits at index count - 1
                                r_popped <= r_top;
                                r_cnt    <= r_cnt - CNT_W'(1);
                                r_lev    <= f_lev(r_cnt);
                                r_ofs    <= f_ofs(r_cnt);
                                r_state  <= S_POP_RDL;
                            end
                        end
                    end
                end
                S_PUSH_RD: begin
                    r_state <= S_PUSH_WR;
                end
                S_PUSH_WR: begin
                    r_top        <= w_land[0] ? r_key : r_top;
                    r_cnt        <= r_cnt + CNT_W'(1);
                    r_done       <= 1'b1;
                    r_status     <= ST_DONE;
                    r_out_popped <= '0;
                    r_out_top    <= w_land[0] ? r_key : r_top;
                    r_out_valid  <= 1'b1;
                    r_out_count  <= r_cnt + CNT_W'(1);
                    r_state      <= S_IDLE;
                end
                S_POP_RDL: begin
                    r_state <= S_POP_LAST;
                end
                S_POP_LAST: begin
                    r_key     <= w_last_key;
                    r_pos_lev <= '0;
                    r_pos_ofs <= '0;
                    r_idx     <= '0;
                    r_state   <= S_POP_RD;
                end
                S_POP_RD: begin
                    r_state <= S_POP_CMP;
                end
                S_POP_CMP: begin
                    if (w_sink) begin
                        if (r_pos_lev == '0) begin
                            r_top <= w_pick;
                        end
                        r_pos_lev <= r_pos_lev + LW'(1);
                        r_pos_ofs <= {r_pos_ofs[OFS_W-2:0], w_pick_r};
                        r_idx     <= w_pick_r ? CNT_W'(w_right) : CNT_W'(w_left);
                        r_state   <= S_POP_RD;
                    end else begin
                        if (r_pos_lev == '0) begin
                            r_top <= r_key;
                        end
                        r_done       <= 1'b1;
                        r_status     <= ST_DONE;
                        r_out_popped <= r_popped;
                        r_out_top    <= (r_pos_lev == '0) ? r_key : r_top;
                        r_out_valid  <= 1'b1;
                        r_out_count  <= r_cnt;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_popped_key = r_out_popped;
    assign o_top_key    = r_out_top;
    assign o_top_valid  = r_out_valid;
    assign o_count      = r_out_count;

    // ---------------------------------------------------------------- assertions
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(w_accept || (r_state != S_IDLE)))
        else $error("result beat without a command in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_out_valid == (r_out_count != '0)))
        else $error("top valid disagrees with count");

    a_sift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_CMP) |-> (r_pos_lev < LW'(NLEV)) && (r_idx < r_cnt))
        else $error("sift position outside the heap");

endmodule

`default_nettype wire
